// ----- rtl/core/iqws_pkg.sv -----
// Package for the issue queue wakeup/select block.
// Holds the transfer payload types and the per-entry record; no dependencies.
package iqws_pkg;

    localparam int REG_W  = 5;
    localparam int SLOT_W = 4;

    // Input transfer: one decoded instruction offer plus one writeback tag
    typedef struct packed {
        logic             insert_valid;
        logic [REG_W-1:0] src_a;
        logic [REG_W-1:0] src_b;
        logic [REG_W-1:0] dest_reg;
        logic             uses_a;
        logic             uses_b;
        logic             ready_a_in;
        logic             ready_b_in;
        logic             wake_valid;
        logic [REG_W-1:0] wake_tag;
    } iqws_req_t;

    // Output transfer: one result per input transfer
    typedef struct packed {
        logic              accepted;
        logic              table_full;
        logic              issued;
        logic [SLOT_W-1:0] issue_slot;
        logic [REG_W-1:0]  issue_src_a;
        logic [REG_W-1:0]  issue_src_b;
        logic [REG_W-1:0]  issue_dest;
    } iqws_rsp_t;

    // One queue entry (valid bit kept apart, it is the only reset state)
    typedef struct packed {
        logic [REG_W-1:0] src_a;
        logic [REG_W-1:0] src_b;
        logic [REG_W-1:0] dest;
        logic             uses_a;
        logic             uses_b;
        logic             ready_a;
        logic             ready_b;
    } iqws_entry_t;

    // Insert status from the entry table
    typedef struct packed {
        logic accepted;
        logic full;
    } iqws_tbl_stat_t;

endpackage

// ----- rtl/core/iqws_stream_if.sv -----
// Valid/ready stream interface used for both channels of the issue queue.
// The payload type is set per instance; depends on nothing else.
interface iqws_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/iqws_table.sv -----
// Entry table of the issue queue: insert into lowest free entry, tag wakeup,
// and release of the selected entry. Depends on iqws_pkg.
module iqws_table
    import iqws_pkg::*;
#(
    parameter int ENTRIES = 16
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  iqws_req_t                 req,
    input  logic [ENTRIES-1:0]        grant,
    output logic [ENTRIES-1:0]        valid_post,
    output iqws_entry_t [ENTRIES-1:0] entry_post,
    output iqws_tbl_stat_t            stat
);

    logic [ENTRIES-1:0]        valid_reg;
    logic [ENTRIES-1:0]        valid_next;
    iqws_entry_t [ENTRIES-1:0] entry_reg;
    logic [ENTRIES-1:0]        free_vec;
    logic [ENTRIES-1:0]        low_free;
    logic [ENTRIES-1:0]        ins_oh;
    iqws_entry_t               new_entry;

    // Lowest free entry, one-hot
    assign free_vec = ~valid_reg;
    assign low_free = free_vec & ((~free_vec) + ENTRIES'(1));
    assign ins_oh   = req.insert_valid ? low_free : '0;

    assign new_entry.src_a   = req.src_a;
    assign new_entry.src_b   = req.src_b;
    assign new_entry.dest    = req.dest_reg;
    assign new_entry.uses_a  = req.uses_a;
    assign new_entry.uses_b  = req.uses_b;
    assign new_entry.ready_a = req.ready_a_in;
    assign new_entry.ready_b = req.ready_b_in;

    assign valid_post    = valid_reg | ins_oh;
    assign stat.accepted = |ins_oh;
    assign stat.full     = &valid_post;

    // Insert then wakeup, per entry; a same-cycle insert sees the tag too
    always_comb
    begin
        iqws_entry_t e;
        for (int i = 0; i < ENTRIES; i++)
        begin
            e = ins_oh[i] ? new_entry : entry_reg[i];
            if (req.wake_valid && (e.src_a == req.wake_tag))
            begin
                e.ready_a = 1'b1;
            end
            if (req.wake_valid && (e.src_b == req.wake_tag))
            begin
                e.ready_b = 1'b1;
            end
            entry_post[i] = e;
        end
    end

    // Issued entry is freed
    assign valid_next = valid_post & ~grant;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload, no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            entry_reg <= entry_post;
        end
    end

endmodule

// ----- rtl/core/iqws_select.sv -----
// Select logic: highest-numbered valid entry with all used sources ready.
// Purely combinational; depends on iqws_pkg.
module iqws_select
    import iqws_pkg::*;
#(
    parameter int ENTRIES = 16
)(
    input  logic [ENTRIES-1:0]        valid_post,
    input  iqws_entry_t [ENTRIES-1:0] entry_post,
    output logic [ENTRIES-1:0]        grant,
    output logic                      issued,
    output logic [SLOT_W-1:0]         issue_slot,
    output iqws_entry_t               pick
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    logic [ENTRIES-1:0] rdy;
    logic [ENTRIES-1:0] rdy_rev;
    logic [ENTRIES-1:0] low_rev;
    logic [IDX_W-1:0]   idx;
    logic [EXT_W-1:0]   idx_ext;

    // Request vector
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rdy[i] = valid_post[i]
                   && (!entry_post[i].uses_a || entry_post[i].ready_a)
                   && (!entry_post[i].uses_b || entry_post[i].ready_b);
        end
    end

    // Highest set bit: bit-reverse, isolate lowest, reverse back
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rdy_rev[i] = rdy[ENTRIES-1-i];
        end
    end

    assign low_rev = rdy_rev & ((~rdy_rev) + ENTRIES'(1));

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            grant[i] = low_rev[ENTRIES-1-i];
        end
    end

    // One-hot to index and AND-OR mux of the picked entry
    always_comb
    begin
        idx  = '0;
        pick = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (grant[i])
            begin
                idx  = idx | IDX_W'(i);
                pick = pick | entry_post[i];
            end
        end
    end

    assign issued     = |grant;
    assign idx_ext    = EXT_W'(idx);
    assign issue_slot = idx_ext[SLOT_W-1:0];

endmodule

// ----- rtl/core/issue_queue_wakeup_select.sv -----
// Issue queue with tag wakeup and highest-entry select.
//
// Channels: req (sink) carries one step: an optional instruction to insert
// and an optional writeback tag. rsp (source) carries exactly one result per
// req transfer: accepted, table_full, and the issued entry if any.
// Each step inserts into the lowest free entry, wakes matching sources
// (including the entry just inserted), then frees and reports the highest
// ready entry. table_full is sampled after insert, before the issue frees.
// Path: the req transfer goes into the input register, then one pass of
// insert/wakeup/select goes into the result register.
// Throughput: one transfer per cycle while rsp is not held (see Stall).
// Reset: the table is emptied and both registers are marked empty.
// Stall: while rsp is held, the result register keeps its value; one more
// req is taken into the input register, then req.ready drops.
// Depends on iqws_pkg, iqws_stream_if, iqws_table and iqws_select.
module issue_queue_wakeup_select
    import iqws_pkg::*;
#(
    parameter int ENTRIES = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    iqws_stream_if.sink          req,
    iqws_stream_if.source        rsp
);

    logic                      in_valid_reg;
    iqws_req_t                 in_reg;
    logic                      out_valid_reg;
    iqws_rsp_t                 out_reg;
    iqws_rsp_t                 out_next;
    logic                      step;
    logic [ENTRIES-1:0]        grant;
    logic [ENTRIES-1:0]        valid_post;
    iqws_entry_t [ENTRIES-1:0] entry_post;
    iqws_tbl_stat_t            stat;
    logic                      issued;
    logic [SLOT_W-1:0]         issue_slot;
    iqws_entry_t               pick;

    // Process the held step when the result register is free or draining
    assign step      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_reg <= req.payload;
        end
    end

    iqws_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .req        (in_reg),
        .grant      (grant),
        .valid_post (valid_post),
        .entry_post (entry_post),
        .stat       (stat)
    );

    iqws_select #(
        .ENTRIES (ENTRIES)
    ) u_select (
        .valid_post (valid_post),
        .entry_post (entry_post),
        .grant      (grant),
        .issued     (issued),
        .issue_slot (issue_slot),
        .pick       (pick)
    );

    // Result assembly
    assign out_next.accepted    = stat.accepted;
    assign out_next.table_full  = stat.full;
    assign out_next.issued      = issued;
    assign out_next.issue_slot  = issue_slot;
    assign out_next.issue_src_a = pick.src_a;
    assign out_next.issue_src_b = pick.src_b;
    assign out_next.issue_dest  = pick.dest;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the issue queue wakeup/select block.
// Depends on iqws_pkg, iqws_stream_if and issue_queue_wakeup_select.
`timescale 1ns / 1ps

module testbench;
    import iqws_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_WAIT  = 8;
    localparam int IDLE_PCT    = 21;
    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;

    iqws_stream_if #(.payload_t(iqws_req_t)) req_if ();
    iqws_stream_if #(.payload_t(iqws_rsp_t)) rsp_if ();

    issue_queue_wakeup_select #(.ENTRIES(ENTRIES)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the issue table
    logic        shadow_valid [ENTRIES];
    iqws_entry_t shadow_entry [ENTRIES];

    iqws_rsp_t pending_results [$];

    int  mismatch_count;
    int  cycle_count;
    int  steps_sent;
    int  inserts_placed;
    int  inserts_rejected;
    int  issues_seen;
    int  full_steps;
    bit  steady;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("Mismatches found");
        $finish;
    end

    // One step of the issue queue: insert, wakeup, select
    function automatic iqws_rsp_t advance_queue(input iqws_req_t s);
        iqws_rsp_t r;
        logic      placed;
        logic      picked;
        logic      all_taken;
        r      = '0;
        placed = 1'b0;
        picked = 1'b0;

        // insert into lowest free entry
        if (s.insert_valid)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!placed && !shadow_valid[i])
                begin
                    shadow_valid[i]         = 1'b1;
                    shadow_entry[i].src_a   = s.src_a;
                    shadow_entry[i].src_b   = s.src_b;
                    shadow_entry[i].dest    = s.dest_reg;
                    shadow_entry[i].uses_a  = s.uses_a;
                    shadow_entry[i].uses_b  = s.uses_b;
                    shadow_entry[i].ready_a = s.ready_a_in;
                    shadow_entry[i].ready_b = s.ready_b_in;
                    placed = 1'b1;
                end
            end
        end
        all_taken = 1'b1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!shadow_valid[i])
                all_taken = 1'b0;
        end

        // wakeup ORs readiness in
        if (s.wake_valid)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (shadow_entry[i].src_a == s.wake_tag)
                    shadow_entry[i].ready_a = 1'b1;
                if (shadow_entry[i].src_b == s.wake_tag)
                    shadow_entry[i].ready_b = 1'b1;
            end
        end

        // select highest ready entry
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!picked && shadow_valid[i]
                && (!shadow_entry[i].uses_a || shadow_entry[i].ready_a)
                && (!shadow_entry[i].uses_b || shadow_entry[i].ready_b))
            begin
                shadow_valid[i] = 1'b0;
                picked          = 1'b1;
                r.issue_slot    = i[SLOT_W-1:0];
                r.issue_src_a   = shadow_entry[i].src_a;
                r.issue_src_b   = shadow_entry[i].src_b;
                r.issue_dest    = shadow_entry[i].dest;
            end
        end

        r.accepted   = placed;
        r.table_full = all_taken;
        r.issued     = picked;
        return r;
    endfunction

    function automatic string fmt_result(input iqws_rsp_t r);
        return $sformatf("acc=%0b full=%0b iss=%0b slot=%0d a=%0d b=%0d d=%0d",
                         r.accepted, r.table_full, r.issued, r.issue_slot,
                         r.issue_src_a, r.issue_src_b, r.issue_dest);
    endfunction

    task automatic log_mismatch(input string what, input iqws_rsp_t want,
                                input iqws_rsp_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] %s", $realtime, what);
            $display("    expected %s", fmt_result(want));
            $display("    actual   %s", fmt_result(got));
        end
    endtask

    // Compare one result transfer against the oldest expectation
    task automatic check_result(input iqws_rsp_t got);
        iqws_rsp_t want;
        string     bad;
        bad = "";
        if (pending_results.size() == 0)
        begin
            log_mismatch("result with nothing expected", '0, got);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.accepted    !== want.accepted)    bad = {bad, " accepted"};
            if (got.table_full  !== want.table_full)  bad = {bad, " table_full"};
            if (got.issued      !== want.issued)      bad = {bad, " issued"};
            if (got.issue_slot  !== want.issue_slot)  bad = {bad, " issue_slot"};
            if (got.issue_src_a !== want.issue_src_a) bad = {bad, " issue_src_a"};
            if (got.issue_src_b !== want.issue_src_b) bad = {bad, " issue_src_b"};
            if (got.issue_dest  !== want.issue_dest)  bad = {bad, " issue_dest"};
            if (bad.len() != 0)
                log_mismatch({"field mismatch:", bad}, want, got);
        end
    endtask

    // Result side: check each transfer, stall at random
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                check_result(rsp_if.payload);
            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Send one step; the expectation is recorded at the transfer
    task automatic send_step(input iqws_req_t s);
        iqws_rsp_t want;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= s;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        want = advance_queue(s);
        pending_results.push_back(want);
        steps_sent++;
        if (want.accepted)
            inserts_placed++;
        else if (s.insert_valid)
            inserts_rejected++;
        if (want.issued)
            issues_seen++;
        if (want.table_full)
            full_steps++;
    endtask

    function automatic iqws_req_t make_step(
        input logic ins, input logic [REG_W-1:0] sa, input logic [REG_W-1:0] sb,
        input logic [REG_W-1:0] dr, input logic ua, input logic ub,
        input logic ra, input logic rb, input logic wv,
        input logic [REG_W-1:0] tag);
        iqws_req_t s;
        s.insert_valid = ins;
        s.src_a        = sa;
        s.src_b        = sb;
        s.dest_reg     = dr;
        s.uses_a       = ua;
        s.uses_b       = ub;
        s.ready_a_in   = ra;
        s.ready_b_in   = rb;
        s.wake_valid   = wv;
        s.wake_tag     = tag;
        return s;
    endfunction

    // Register numbers clustered at both ends so wakeups hit often
    function automatic logic [REG_W-1:0] pick_reg();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return REG_W'($urandom_range(3));
        else if (roll < 75)
            return REG_W'($urandom_range(31, 28));
        else
            return REG_W'($urandom_range(31));
    endfunction

    function automatic iqws_req_t random_step(input int insert_pct,
                                              input int wake_pct);
        return make_step($urandom_range(99) < insert_pct,
                         pick_reg(), pick_reg(), REG_W'($urandom_range(31)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         $urandom_range(99) < 30, $urandom_range(99) < 30,
                         $urandom_range(99) < wake_pct, pick_reg());
    endfunction

    // Empty steps, ready and unused sources, wakeup of a same-step insert
    task automatic test_unit_cases();
        send_step(make_step(0, 31, 31, 31, 1, 1, 1, 1, 0, 31));
        send_step(make_step(1, 31, 31, 31, 1, 1, 1, 1, 0, 0));
        send_step(make_step(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_step(make_step(1, 5, 0, 1, 1, 0, 0, 0, 0, 0));
        send_step(make_step(1, 0, 5, 2, 0, 1, 0, 0, 1, 5));
        send_step(make_step(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_step(make_step(1, 10, 21, 3, 1, 1, 1, 0, 1, 10));
        send_step(make_step(0, 0, 0, 0, 0, 0, 0, 0, 1, 21));
    endtask

    // Fill all entries, reject one insert on a full table, refill a freed slot
    task automatic test_full_table();
        for (int i = 0; i < ENTRIES; i++)
            send_step(make_step(1, 7, 9, REG_W'(i), 1, 1, 0, 1, 0, 0));
        send_step(make_step(1, 31, 31, 31, 0, 0, 1, 1, 1, 7));
        send_step(make_step(1, 12, 13, 14, 1, 1, 1, 1, 0, 0));
    endtask

    task automatic test_random_mix(input int count, input int insert_pct,
                                   input int wake_pct);
        for (int i = 0; i < count; i++)
            send_step(random_step(insert_pct, wake_pct));
    endtask

    task automatic test_back_to_back(input int count);
        steady = 1'b1;
        test_random_mix(count, 50, 50);
        steady = 1'b0;
    endtask

    // Stimulus sequence
    initial
    begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        steady           = 1'b0;
        mismatch_count   = 0;
        steps_sent       = 0;
        inserts_placed   = 0;
        inserts_rejected = 0;
        issues_seen      = 0;
        full_steps       = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_entry[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unit_cases();
        test_full_table();
        test_random_mix(430, 80, 25);
        test_back_to_back(430);
        test_random_mix(430, 30, 70);
        req_if.valid <= 1'b0;

        // let the pipeline empty out
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d steps: %0d inserts placed, %0d rejected, %0d issues",
                 steps_sent, inserts_placed, inserts_rejected, issues_seen);
        $display("Table reported full on %0d steps; %0d mismatches",
                 full_steps, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/iqws_pkg.sv
rtl/core/iqws_stream_if.sv
rtl/core/iqws_table.sv
rtl/core/iqws_select.sv
rtl/core/issue_queue_wakeup_select.sv
bench/testbench.sv
